// ----- hdl/mpe_pkg.sv -----
// Shared types and constants for the Mandelbrot pixel escape core.
// Holds field widths, register indexes, colour constants, controller states
// and the command and status bundles between controller and datapath.
package mpe_pkg;

    localparam int PIX_W    = 12;
    localparam int DIM_W    = 13;
    localparam int LIMIT_W  = 16;
    localparam int ZOOM_W   = 32;
    localparam int SHIFT_W  = 7;
    localparam int COLOUR_W = 32;
    localparam int MAG_W    = 16;
    localparam int IDX_W    = 3;
    localparam int DEN_W    = ZOOM_W + DIM_W;
    localparam int IN_W     = 2 * PIX_W;
    localparam int OUT_W    = LIMIT_W + COLOUR_W;
    localparam int USER_W   = 2;
    localparam int DIM_MAX  = 4096;

    typedef logic [IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FRAME_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_ITER_LIMIT   = 3'd2;
    localparam t_cfg_idx CFG_ZOOM         = 3'd3;
    localparam t_cfg_idx CFG_CENTRE_RE    = 3'd4;
    localparam t_cfg_idx CFG_CENTRE_IM    = 3'd5;
    localparam t_cfg_idx CFG_COLOUR_SHIFT = 3'd6;

    localparam logic [COLOUR_W-1:0] COLOUR_BASE = 32'h0034_0000;
    localparam logic [COLOUR_W-1:0] COLOUR_STEP = 32'd10000;
    localparam logic [COLOUR_W-1:0] SHIFT_STEP  = 32'd100000;

    function automatic logic [COLOUR_W-1:0] colour_step(input logic [2:0] k);
        return COLOUR_W'(k) * COLOUR_STEP;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_MAP_WAIT,
        ST_SCALE,
        ST_ITER,
        ST_ABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ASM,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic add_centre;
        logic scale;
        logic z_update;
        logic take_abs;
        logic mul_lo;
        logic mul_hi;
        logic assemble;
        logic count_inc;
        logic set_esc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic limit_hit;
        logic escape;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/mandelbrot_pixel_escape_core.sv -----
// Top level of the Mandelbrot pixel escape core: controller plus datapath.
// Depends on mpe_pkg, mpe_ctrl, mpe_dp and mpe_div.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  s        | in        | i_s_tvalid / o_s_tready | tdata: pixel_x, pixel_y
//  m        | out       | o_m_tvalid / i_m_tready | tdata: iteration_count, pixel_colour
//           |           |                         | tuser: escaped, in_frame
//  cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_wdata
//
// One item at a time: the mapping takes 33+FRAC_BITS divider steps and each
// iteration six controller steps through the split multiplier.
// Reset is synchronous, active low; configuration returns to its defaults.
// A finished result waits in the output register while the next item is taken;
// the core stalls before delivery only if that register is still full.
module mandelbrot_pixel_escape_core
    import mpe_pkg::*;
#(
    parameter  int FRAC_BITS = 28,
    localparam int CFG_W     = (FRAC_BITS + 8 > ZOOM_W) ? FRAC_BITS + 8 : ZOOM_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,   // pixel_x[11:0], pixel_y[23:12]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,   // iteration_count[15:0], pixel_colour[47:16]
    output logic [USER_W-1:0] o_m_tuser    // escaped[0], in_frame[1]
);

    t_cmd w_cmd;
    t_sts w_sts;

    mpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mpe_dp #(
        .FRAC_BITS (FRAC_BITS),
        .CFG_W     (CFG_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over an undelivered item");

    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !w_sts.div_done)
        else $error("divider done right after start");

    a_iter_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.z_update |-> !w_sts.limit_hit)
        else $error("iteration step past the limit");

endmodule

// ----- hdl/mpe_div.sv -----
// Restoring divider for the pixel-to-plane mapping, one quotient bit a cycle.
// Produces the saturated signed offset |mag|*2^(17+FRAC_BITS)/den; uses mpe_pkg.
module mpe_div
    import mpe_pkg::*;
#(
    parameter int FRAC_BITS = 28
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [MAG_W-1:0]             i_mag,
    input  logic                         i_neg,
    input  logic [DEN_W-1:0]             i_den,
    output logic                         o_done,
    output logic signed [FRAC_BITS+7:0]  o_res
);

    localparam int VAL_W = FRAC_BITS + 8;
    localparam int STEPS = MAG_W + 17 + FRAC_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [VAL_W-1:0] VAL_SIGN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};

    logic                      r_busy;
    logic                      r_fin;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [MAG_W-1:0]          r_dvd;
    logic [DEN_W-1:0]          r_rem;
    logic [DEN_W-1:0]          r_den;
    logic [VAL_W-1:0]          r_q;
    logic                      r_ovf;
    logic                      r_neg;
    logic                      r_zero;
    logic signed [VAL_W-1:0]   r_res;

    logic [DEN_W:0]            trial;
    logic                      ge;
    logic [VAL_W-1:0]          sat_mag;

    assign trial = {r_rem, r_dvd[MAG_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_comb begin
        if (r_neg) begin
            sat_mag = (r_ovf || r_q > VAL_SIGN) ? VAL_SIGN : r_q;
        end else begin
            sat_mag = (r_ovf || r_q > VAL_MAX) ? VAL_MAX : r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_dvd  <= i_mag;
            r_rem  <= '0;
            r_den  <= i_den;
            r_q    <= '0;
            r_ovf  <= 1'b0;
            r_neg  <= i_neg;
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_dvd <= {r_dvd[MAG_W-2:0], 1'b0};
            r_rem <= ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_q   <= {r_q[VAL_W-2:0], ge};
            r_ovf <= r_ovf | r_q[VAL_W-1];
        end
        if (r_fin) begin
            if (r_zero) begin
                r_res <= '0;
            end else if (r_neg) begin
                r_res <= $signed(VAL_W'(~sat_mag + 1'b1));
            end else begin
                r_res <= $signed(sat_mag);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- hdl/mpe_ctrl.sv -----
// Controller state machine: sequences mapping, iteration steps and output.
// Drives the datapath through t_cmd and reads t_sts; uses mpe_pkg.
module mpe_ctrl
    import mpe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MAP;
                end
            end
            ST_MAP: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_MAP_WAIT;
            end
            ST_MAP_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.add_centre = 1'b1;
                    n_state          = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_ITER;
            end
            ST_ITER: begin
                if (i_sts.limit_hit) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.z_update = 1'b1;
                    n_state        = ST_ABS;
                end
            end
            ST_ABS: begin
                o_cmd.take_abs = 1'b1;
                n_state        = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_ASM;
            end
            ST_ASM: begin
                o_cmd.assemble = 1'b1;
                n_state        = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.escape) begin
                    o_cmd.set_esc = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.count_inc = 1'b1;
                    n_state         = ST_ITER;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);

endmodule

// ----- hdl/mpe_dp.sv -----
// Datapath: configuration registers, mapping dividers, z iteration with a
// split multiplier, and the output register; uses mpe_pkg and mpe_div.
module mpe_dp
    import mpe_pkg::*;
#(
    parameter int FRAC_BITS = 28,
    parameter int CFG_W     = 36
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic [IN_W-1:0]      i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata,
    output logic [USER_W-1:0]    o_m_tuser,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts
);

    localparam int VAL_W = FRAC_BITS + 8;
    localparam int HALF  = (VAL_W + 1) / 2;
    localparam int HIW   = VAL_W - HALF;
    localparam int PRW   = FRAC_BITS + 16;
    localparam int SW    = PRW + 2;
    localparam int FW    = 2 * VAL_W;
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [PRW:0] ESC_LIM = (PRW+1)'(16) << FRAC_BITS;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SW-1:0] v);
        logic in_range;
        in_range = (v[SW-1:VAL_W-1] == {(SW-VAL_W+1){v[SW-1]}});
        if (in_range) begin
            return v[VAL_W-1:0];
        end
        return v[SW-1] ? VAL_MIN : VAL_MAX;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim);
        return (int'(dim) > DIM_MAX) ? DIM_W'(DIM_MAX) : dim;
    endfunction

    logic [DIM_W-1:0]          r_frame_w;
    logic [DIM_W-1:0]          r_frame_h;
    logic [LIMIT_W-1:0]        r_limit;
    logic [ZOOM_W-1:0]         r_zoom;
    logic signed [VAL_W-1:0]   r_centre_re;
    logic signed [VAL_W-1:0]   r_centre_im;
    logic [SHIFT_W-1:0]        r_shift;

    logic [PIX_W-1:0]          r_px;
    logic [PIX_W-1:0]          r_py;
    logic                      r_inframe;
    logic signed [VAL_W-1:0]   r_sx;
    logic signed [VAL_W-1:0]   r_cr;
    logic signed [VAL_W-1:0]   r_ci;
    logic signed [VAL_W-1:0]   r_zr;
    logic signed [VAL_W-1:0]   r_zi;
    logic [VAL_W-1:0]          r_ar;
    logic [VAL_W-1:0]          r_ai;
    logic                      r_xneg;
    logic [VAL_W+HALF-1:0]     r_plo_rr;
    logic [VAL_W+HALF-1:0]     r_plo_ii;
    logic [VAL_W+HALF-1:0]     r_plo_ri;
    logic [VAL_W+HIW-1:0]      r_phi_rr;
    logic [VAL_W+HIW-1:0]      r_phi_ii;
    logic [VAL_W+HIW-1:0]      r_phi_ri;
    logic [PRW-1:0]            r_mrr;
    logic [PRW-1:0]            r_mii;
    logic [PRW-1:0]            r_mri;
    logic [LIMIT_W-1:0]        r_cnt;
    logic                      r_esc;

    logic                      r_out_valid;
    logic [LIMIT_W-1:0]        r_out_cnt;
    logic                      r_out_esc;
    logic                      r_out_inf;
    logic [COLOUR_W-1:0]       r_out_colour;

    logic [DIM_W-1:0]          dim_x;
    logic [DIM_W-1:0]          dim_y;
    logic [DIM_W-1:0]          half_x;
    logic [DIM_W-1:0]          half_y;
    logic                      neg_x;
    logic                      neg_y;
    logic [DIM_W-1:0]          diff_x;
    logic [DIM_W-1:0]          diff_y;
    logic [DEN_W-1:0]          den_x;
    logic [DEN_W-1:0]          den_y;
    logic                      done_x;
    logic                      done_y;
    logic signed [VAL_W-1:0]   off_x;
    logic signed [VAL_W-1:0]   off_y;

    logic [FW-1:0]             full_rr;
    logic [FW-1:0]             full_ii;
    logic [FW-1:0]             full_ri;
    logic signed [SW-1:0]      t_rr;
    logic signed [SW-1:0]      t_ii;
    logic signed [SW-1:0]      t_ri2;
    logic signed [SW-1:0]      sum_r;
    logic signed [SW-1:0]      sum_i;
    logic [PRW:0]              mag_sum;
    logic [PIX_W-1:0]          in_px;
    logic [PIX_W-1:0]          in_py;

    assign in_px = i_s_tdata[PIX_W-1:0];
    assign in_py = i_s_tdata[2*PIX_W-1:PIX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w   <= DIM_W'(800);
            r_frame_h   <= DIM_W'(800);
            r_limit     <= LIMIT_W'(50);
            r_zoom      <= ZOOM_W'(65536);
            r_centre_re <= '0;
            r_centre_im <= '0;
            r_shift     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_w   <= i_cfg_wdata[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_h   <= i_cfg_wdata[DIM_W-1:0];
                CFG_ITER_LIMIT:   r_limit     <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_ZOOM:         r_zoom      <= i_cfg_wdata[ZOOM_W-1:0];
                CFG_CENTRE_RE:    r_centre_re <= $signed(i_cfg_wdata[VAL_W-1:0]);
                CFG_CENTRE_IM:    r_centre_im <= $signed(i_cfg_wdata[VAL_W-1:0]);
                CFG_COLOUR_SHIFT: r_shift     <= i_cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign dim_x  = clamp_dim(r_frame_w);
    assign dim_y  = clamp_dim(r_frame_h);
    assign half_x = dim_x >> 1;
    assign half_y = dim_y >> 1;
    assign neg_x  = {1'b0, r_px} < half_x;
    assign neg_y  = {1'b0, r_py} < half_y;
    assign diff_x = neg_x ? half_x - {1'b0, r_px} : {1'b0, r_px} - half_x;
    assign diff_y = neg_y ? half_y - {1'b0, r_py} : {1'b0, r_py} - half_y;
    assign den_x  = DEN_W'(r_zoom) * DEN_W'(dim_x);
    assign den_y  = DEN_W'(r_zoom) * DEN_W'(dim_y);

    mpe_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (MAG_W'(diff_x)),
        .i_neg   (neg_x),
        .i_den   (den_x),
        .o_done  (done_x),
        .o_res   (off_x)
    );

    mpe_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (MAG_W'(diff_y)),
        .i_neg   (neg_y),
        .i_den   (den_y),
        .o_done  (done_y),
        .o_res   (off_y)
    );

    assign full_rr = FW'(r_plo_rr) + (FW'(r_phi_rr) << HALF);
    assign full_ii = FW'(r_plo_ii) + (FW'(r_phi_ii) << HALF);
    assign full_ri = FW'(r_plo_ri) + (FW'(r_phi_ri) << HALF);

    assign t_rr  = $signed({2'b00, r_mrr});
    assign t_ii  = $signed({2'b00, r_mii});
    assign t_ri2 = $signed({1'b0, r_mri, 1'b0});
    assign sum_r = t_rr - t_ii + SW'(r_cr);
    assign sum_i = r_xneg ? SW'(r_ci) - t_ri2 : SW'(r_ci) + t_ri2;
    assign mag_sum = {1'b0, r_mrr} + {1'b0, r_mii};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px      <= in_px;
            r_py      <= in_py;
            r_inframe <= ({1'b0, in_px} < r_frame_w) && ({1'b0, in_py} < r_frame_h);
            r_zr      <= '0;
            r_zi      <= '0;
            r_mrr     <= '0;
            r_mii     <= '0;
            r_mri     <= '0;
            r_xneg    <= 1'b0;
            r_cnt     <= '0;
            r_esc     <= 1'b0;
        end
        if (i_cmd.add_centre) begin
            r_sx <= sat_val(SW'(off_x) + SW'(r_centre_re));
            r_ci <= sat_val(SW'(off_y) + SW'(r_centre_im));
        end
        if (i_cmd.scale) begin
            r_cr <= sat_val(SW'(r_sx) + SW'(r_sx >>> 1));
        end
        if (i_cmd.z_update) begin
            r_zr <= sat_val(sum_r);
            r_zi <= sat_val(sum_i);
        end
        if (i_cmd.take_abs) begin
            r_ar   <= r_zr[VAL_W-1] ? $unsigned(-r_zr) : $unsigned(r_zr);
            r_ai   <= r_zi[VAL_W-1] ? $unsigned(-r_zi) : $unsigned(r_zi);
            r_xneg <= r_zr[VAL_W-1] ^ r_zi[VAL_W-1];
        end
        if (i_cmd.mul_lo) begin
            r_plo_rr <= r_ar * r_ar[HALF-1:0];
            r_plo_ii <= r_ai * r_ai[HALF-1:0];
            r_plo_ri <= r_ar * r_ai[HALF-1:0];
        end
        if (i_cmd.mul_hi) begin
            r_phi_rr <= r_ar * r_ar[VAL_W-1:HALF];
            r_phi_ii <= r_ai * r_ai[VAL_W-1:HALF];
            r_phi_ri <= r_ar * r_ai[VAL_W-1:HALF];
        end
        if (i_cmd.assemble) begin
            r_mrr <= full_rr[FRAC_BITS +: PRW];
            r_mii <= full_ii[FRAC_BITS +: PRW];
            r_mri <= full_ri[FRAC_BITS +: PRW];
        end
        if (i_cmd.count_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.set_esc) begin
            r_esc <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_cnt    <= r_cnt;
            r_out_esc    <= r_esc;
            r_out_inf    <= r_inframe;
            r_out_colour <= r_esc ? COLOUR_BASE - colour_step(r_cnt[2:0])
                                    + COLOUR_W'(r_shift) * SHIFT_STEP : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.div_done  = done_x & done_y;
    assign o_sts.limit_hit = r_cnt >= r_limit;
    assign o_sts.escape    = mag_sum > ESC_LIM;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_colour, r_out_cnt};
    assign o_m_tuser  = {r_out_inf, r_out_esc};

endmodule
